// ===== rtl/core/atgsr_pkg.sv =====
// Shared types and constants for the tile grid slide resolver.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package atgsr_pkg;

  // Stream word layouts, padded to whole bytes.
  localparam int unsigned IN_W  = 112;
  localparam int unsigned OUT_W = 56;

  // Wall memory word: 64 tile flags per word.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;
  localparam logic [BIT_W-1:0]  BIT_MAX   = 6'd63;
  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

  // Command queue between front and back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_TOP   = 3'd5;

  localparam logic [6:0]  RST_MAP_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_MAP_HEIGHT = 7'd64;
  localparam logic [14:0] RST_HALF_X     = 15'd64;
  localparam logic [14:0] RST_HALF_Y     = 15'd128;
  localparam logic [14:0] RST_HALF_Z     = 15'd64;
  localparam logic [14:0] RST_WALL_TOP   = 15'd512;

  // Request kind carried in tuser.
  localparam logic REQ_MOVE = 1'b1;

  typedef enum logic [1:0] {
    CMD_SKIP = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_MOVE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [11:0]        tile_index;
    logic               tile_wall;
    logic signed [15:0] old_x;
    logic signed [15:0] old_y;
    logic signed [15:0] old_z;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] new_z;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  map_width;
    logic [6:0]  map_height;
    logic [14:0] half_size_x;
    logic [14:0] half_size_y;
    logic [14:0] half_size_z;
    logic [14:0] wall_top;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic wr_val;
    logic rd_en;
  } mem_ctrl_t;

  // Width of a linear tile address, at least one bit above the word offset.
  function automatic int unsigned lin_addr_w(input int unsigned side);
    int unsigned w;
    w = $clog2(side * side);
    return (w > BIT_W) ? w : BIT_W + 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aabb_tile_grid_slide_resolve.sv =====
// A word is registered in the command queue before the back end sees it; a load's flag is
// written in IDLE as it is popped. Each of a move's one to three box tests runs SETUP and
// SPAN, then, if the box meets the grid and wall span, ROW and RD per tile row and CHK per
// word of the row, then EVAL; the move ends in OUT. The back end takes one item at a time.
// Reset: configuration returns to its defaults and the wall memory, 2**(LA_W-6) words (64
// at MAX_SIDE 64), is swept to zero, one word a cycle; no word is accepted meanwhile.
`default_nettype none

module aabb_tile_grid_slide_resolve import atgsr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tile_index[11:0], tile_wall[12], old_x, old_y, old_z, new_x, new_y, new_z
  // (16 bits each from bit 13), zero pad [111:109]
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // req_type: 0 load a tile flag, 1 resolve a move
  input  wire logic [0:0]            s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // res_x[15:0], res_y[31:16], res_z[47:32], hit[48], zero pad [55:49]
  output logic [OUT_W-1:0]           m_axis_tdata,
  // Configuration write port.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LA_W = lin_addr_w(MAX_SIDE);
  localparam int unsigned WA_W = LA_W - BIT_W;

  cfg_t              cfg_q;
  cmd_t              head;
  logic              head_valid, pop, clr_busy;
  mem_ctrl_t         mem_ctrl;
  logic [WA_W-1:0]   wr_addr, rd_addr;
  logic [BIT_W-1:0]  wr_bit;
  logic [WORD_W-1:0] rd_data;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width   <= RST_MAP_WIDTH;
      cfg_q.map_height  <= RST_MAP_HEIGHT;
      cfg_q.half_size_x <= RST_HALF_X;
      cfg_q.half_size_y <= RST_HALF_Y;
      cfg_q.half_size_z <= RST_HALF_Z;
      cfg_q.wall_top    <= RST_WALL_TOP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_WIDTH:  cfg_q.map_width   <= cfg_data_i[6:0];
        CFG_MAP_HEIGHT: cfg_q.map_height  <= cfg_data_i[6:0];
        CFG_HALF_X:     cfg_q.half_size_x <= cfg_data_i;
        CFG_HALF_Y:     cfg_q.half_size_y <= cfg_data_i;
        CFG_HALF_Z:     cfg_q.half_size_z <= cfg_data_i;
        CFG_WALL_TOP:   cfg_q.wall_top    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: classify each word and hold it in the command queue.
  atgsr_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser[0]),
    .accept_en_i  (!clr_busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back: flag writes and the box test sequencer, with the result register.
  atgsr_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .mem_ctrl_o   (mem_ctrl),
    .wr_addr_o    (wr_addr),
    .wr_bit_o     (wr_bit),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

  // Wall flags, cleared by a sweep after reset.
  atgsr_wall_mem #(
    .WA_W (WA_W)
  ) u_wall_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mem_ctrl),
    .wr_addr_i  (wr_addr),
    .wr_bit_i   (wr_bit),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  // Hold off new words while the sweep runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready)
    else $error("word accepted during wall memory sweep");

  // The back end must leave the memory alone during the sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !mem_ctrl.wr_en && !mem_ctrl.rd_en)
    else $error("wall memory accessed during sweep");

  // Flag writes and box test reads never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctrl.wr_en && mem_ctrl.rd_en))
    else $error("wall memory read and write in one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/atgsr_front.sv =====
// Front end: takes stream words, classifies them and queues commands.
// Depends on atgsr_pkg.
`default_nettype none

module atgsr_front import atgsr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire logic [IN_W-1:0] s_data_i,
  input  wire logic            s_user_i,
  input  wire logic            accept_en_i,
  output logic                 head_valid_o,
  output cmd_t                 head_o,
  input  wire logic            pop_i
);

  localparam int unsigned TILES = MAX_SIDE * MAX_SIDE;

  cmd_t            cmd;
  cmd_t            q_mem_q [Q_DEPTH];
  logic [Q_AW:0]   wr_ptr_q, rd_ptr_q;
  logic            full, push, idx_ok;

  assign idx_ok = ({5'b0, s_data_i[11:0]} < 17'(TILES));

  always_comb begin
    cmd.tile_index = s_data_i[11:0];
    cmd.tile_wall  = s_data_i[12];
    cmd.old_x      = s_data_i[28:13];
    cmd.old_y      = s_data_i[44:29];
    cmd.old_z      = s_data_i[60:45];
    cmd.new_x      = s_data_i[76:61];
    cmd.new_y      = s_data_i[92:77];
    cmd.new_z      = s_data_i[108:93];
    if (s_user_i == REQ_MOVE) begin
      cmd.kind = CMD_MOVE;
    end else if (idx_ok) begin
      cmd.kind = CMD_LOAD;
    end else begin
      cmd.kind = CMD_SKIP;
    end
  end

  assign full = (wr_ptr_q[Q_AW] != rd_ptr_q[Q_AW]) &&
                (wr_ptr_q[Q_AW-1:0] == rd_ptr_q[Q_AW-1:0]);
  assign s_ready_o    = !full && accept_en_i;
  assign push         = s_valid_i && s_ready_o;
  assign head_valid_o = (wr_ptr_q != rd_ptr_q);
  assign head_o       = q_mem_q[rd_ptr_q[Q_AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && head_valid_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q[Q_AW-1:0]] <= cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atgsr_wall_mem.sv =====
// Wall flag memory, 64 flags per word, with a clearing sweep after reset.
// Depends on atgsr_pkg.
`default_nettype none

module atgsr_wall_mem import atgsr_pkg::*; #(
  parameter int unsigned WA_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  mem_ctrl_t              ctrl_i,
  input  wire logic [WA_W-1:0]   wr_addr_i,
  input  wire logic [BIT_W-1:0]  wr_bit_i,
  input  wire logic [WA_W-1:0]   rd_addr_i,
  output logic      [WORD_W-1:0] rd_data_o,
  output logic                   clr_busy_o
);

  localparam int unsigned DEPTH = 2 ** WA_W;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic [WA_W-1:0]   clr_cnt_q;
  logic              clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i][wr_bit_i] <= ctrl_i.wr_val;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/atgsr_back.sv =====
// Back end: writes wall flags and runs the up-to-three box tests of a move,
// sweeping covered tile rows word by word. Depends on atgsr_pkg.
`default_nettype none

module atgsr_back import atgsr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cfg_t                     cfg_i,
  input  wire logic                head_valid_i,
  input  cmd_t                     head_i,
  output logic                     pop_o,
  output mem_ctrl_t                mem_ctrl_o,
  output logic [lin_addr_w(MAX_SIDE)-BIT_W-1:0] wr_addr_o,
  output logic [BIT_W-1:0]         wr_bit_o,
  output logic [lin_addr_w(MAX_SIDE)-BIT_W-1:0] rd_addr_o,
  input  wire logic [WORD_W-1:0]   rd_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OUT_W-1:0]         out_data_o
);

  localparam int unsigned LA_W = lin_addr_w(MAX_SIDE);
  localparam int unsigned WA_W = LA_W - BIT_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SETUP = 8'b0000_0010,
    ST_SPAN  = 8'b0000_0100,
    ST_ROW   = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_CHK   = 8'b0010_0000,
    ST_EVAL  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    STG_NEW = 2'd0,
    STG_X   = 2'd1,
    STG_Z   = 2'd2
  } stage_e;

  state_e state_q, state_d;
  stage_e stage_q, stage_d;

  cmd_t               cmd_q, cmd_d;
  logic signed [15:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               hit_q, hit_d, t_hit_q, t_hit_d, y_ok_q, y_ok_d;
  logic signed [9:0]  c_lo_q, c_lo_d, c_hi_q, c_hi_d;
  logic signed [9:0]  r_lo_q, r_lo_d, r_hi_q, r_hi_d, r_q, r_d;
  logic [LA_W-1:0]    st_q, st_d, en_q, en_d;
  logic [WA_W-1:0]    wd_q, wd_d;
  logic               out_valid_q, load_out;
  logic [OUT_W-1:0]   out_data_q;

  // Map extent clamped to the grid size.
  logic signed [9:0]  wv, hv, wm1, hm1;
  // Box edges in Q8.8, one bit of headroom each way.
  logic signed [17:0] cxe, cye, cze, hxe, hye, hze, wte;
  logic signed [17:0] bx0, bx1m, by0, by1, bz0, bz1m;
  logic signed [9:0]  tx_lo, tx_hi, tz_lo, tz_hi;
  logic [17:0]        row_base, lin_st, lin_en;
  logic [LA_W-1:0]    la_load;
  logic               at_st, at_en, word_hit, row_end, rd_next;
  logic [BIT_W-1:0]   sb, eb;
  logic [WORD_W-1:0]  mask;

  assign wv  = ({3'b0, cfg_i.map_width} > 10'(MAX_SIDE)) ? 10'(MAX_SIDE)
                                                         : {3'b0, cfg_i.map_width};
  assign hv  = ({3'b0, cfg_i.map_height} > 10'(MAX_SIDE)) ? 10'(MAX_SIDE)
                                                          : {3'b0, cfg_i.map_height};
  assign wm1 = wv - 10'sd1;
  assign hm1 = hv - 10'sd1;

  assign cxe = {{2{cx_q[15]}}, cx_q};
  assign cye = {{2{cy_q[15]}}, cy_q};
  assign cze = {{2{cz_q[15]}}, cz_q};
  assign hxe = {3'b0, cfg_i.half_size_x};
  assign hye = {3'b0, cfg_i.half_size_y};
  assign hze = {3'b0, cfg_i.half_size_z};
  assign wte = {3'b0, cfg_i.wall_top};

  assign bx0  = cxe - hxe;
  assign bx1m = cxe + hxe - 18'sd1;
  assign by0  = cye - hye;
  assign by1  = cye + hye;
  assign bz0  = cze - hze;
  assign bz1m = cze + hze - 18'sd1;

  // Floor to tile coordinates: first and last tile the box strictly enters.
  assign tx_lo = bx0[17:8];
  assign tx_hi = bx1m[17:8];
  assign tz_lo = bz0[17:8];
  assign tz_hi = bz1m[17:8];

  assign row_base = 18'(r_q[8:0]) * 18'(wv[8:0]);
  assign lin_st   = row_base + 18'(c_lo_q[8:0]);
  assign lin_en   = row_base + 18'(c_hi_q[8:0]);
  assign la_load  = LA_W'(head_i.tile_index);

  assign at_st    = (wd_q == st_q[LA_W-1:BIT_W]);
  assign at_en    = (wd_q == en_q[LA_W-1:BIT_W]);
  assign sb       = at_st ? st_q[BIT_W-1:0] : '0;
  assign eb       = at_en ? en_q[BIT_W-1:0] : BIT_MAX;
  assign mask     = (WORD_ONES << sb) & (WORD_ONES >> (BIT_MAX - eb));
  assign word_hit = |(rd_data_i & mask);
  assign row_end  = (r_q == r_hi_q);
  assign rd_next  = (state_q == ST_CHK) && !word_hit && !at_en;

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    cmd_d   = cmd_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    hit_d   = hit_q;
    t_hit_d = t_hit_q;
    y_ok_d  = y_ok_q;
    c_lo_d  = c_lo_q;
    c_hi_d  = c_hi_q;
    r_lo_d  = r_lo_q;
    r_hi_d  = r_hi_q;
    r_d     = r_q;
    st_d    = st_q;
    en_d    = en_q;
    wd_d    = wd_q;
    pop_o   = 1'b0;
    load_out = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          if (head_i.kind == CMD_MOVE) begin
            cmd_d   = head_i;
            cx_d    = head_i.new_x;
            cy_d    = head_i.new_y;
            cz_d    = head_i.new_z;
            hit_d   = 1'b0;
            stage_d = STG_NEW;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        y_ok_d  = (by0 < wte) && (by1 > 18'sd0);
        c_lo_d  = tx_lo[9] ? 10'sd0 : tx_lo;
        c_hi_d  = (tx_hi > wm1) ? wm1 : tx_hi;
        r_lo_d  = tz_lo[9] ? 10'sd0 : tz_lo;
        r_hi_d  = (tz_hi > hm1) ? hm1 : tz_hi;
        state_d = ST_SPAN;
      end
      ST_SPAN: begin
        if (!y_ok_q || (c_lo_q > c_hi_q) || (r_lo_q > r_hi_q)) begin
          t_hit_d = 1'b0;
          state_d = ST_EVAL;
        end else begin
          r_d     = r_lo_q;
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        st_d    = lin_st[LA_W-1:0];
        en_d    = lin_en[LA_W-1:0];
        wd_d    = lin_st[LA_W-1:BIT_W];
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (word_hit) begin
          t_hit_d = 1'b1;
          state_d = ST_EVAL;
        end else if (at_en) begin
          if (row_end) begin
            t_hit_d = 1'b0;
            state_d = ST_EVAL;
          end else begin
            r_d     = r_q + 10'sd1;
            state_d = ST_ROW;
          end
        end else begin
          wd_d = wd_q + 1'b1;
        end
      end
      ST_EVAL: begin
        case (stage_q)
          STG_NEW: begin
            if (t_hit_q) begin
              // Fall back to the old y and z, keep the proposed x.
              hit_d   = 1'b1;
              cy_d    = cmd_q.old_y;
              cz_d    = cmd_q.old_z;
              stage_d = STG_X;
              state_d = ST_SETUP;
            end else begin
              state_d = ST_OUT;
            end
          end
          STG_X: begin
            if (t_hit_q) begin
              cx_d = cmd_q.old_x;
            end
            cz_d    = cmd_q.new_z;
            stage_d = STG_Z;
            state_d = ST_SETUP;
          end
          default: begin
            if (t_hit_q) begin
              cz_d = cmd_q.old_z;
            end
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_ctrl_o.wr_en  = (state_q == ST_IDLE) && head_valid_i && (head_i.kind == CMD_LOAD);
    mem_ctrl_o.wr_val = head_i.tile_wall;
    mem_ctrl_o.rd_en  = (state_q == ST_RD) || rd_next;
    wr_addr_o         = la_load[LA_W-1:BIT_W];
    wr_bit_o          = la_load[BIT_W-1:0];
    rd_addr_o         = rd_next ? wd_q + 1'b1 : wd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= STG_NEW;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    hit_q   <= hit_d;
    t_hit_q <= t_hit_d;
    y_ok_q  <= y_ok_d;
    c_lo_q  <= c_lo_d;
    c_hi_q  <= c_hi_d;
    r_lo_q  <= r_lo_d;
    r_hi_q  <= r_hi_d;
    r_q     <= r_d;
    st_q    <= st_d;
    en_q    <= en_d;
    wd_q    <= wd_d;
    if (load_out) begin
      out_data_q <= {7'b0, hit_q, cz_q, cy_q, cx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the tile grid slide resolver: directed table, then random phases.
// Depends on atgsr_pkg and aabb_tile_grid_slide_resolve; needs no files or arguments.

module testbench;
  import atgsr_pkg::*;

  localparam int  SIDE        = 64;
  localparam int  TILE_Q      = 256;   // one tile edge in Q8.8
  localparam int  SETTLE      = 16;    // cycles for queued loads to retire
  localparam int  LONG_HOLD   = 300;
  localparam int  STALL_LIMIT = 5000;  // well above the slowest move
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } landing_t;

  // One row of the directed table. Typed rows run on a free path, so the
  // landing is the proposed centre with no hit.
  typedef struct packed {
    logic               kind;
    logic [11:0]        idx;
    logic               wall;
    logic signed [15:0] ox, oy, oz, nx, ny, nz;
    logic               typed;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // tile_index[11:0], tile_wall[12], old_x, old_y, old_z, new_x, new_y, new_z
  // (16 bits each from bit 13), zero pad [111:109]
  logic [IN_W-1:0]  s_axis_tdata = '0;
  // req_type: 0 load a tile flag, 1 resolve a move
  logic [0:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // res_x[15:0], res_y[31:16], res_z[47:32], hit[48], zero pad [55:49]
  logic [OUT_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Mirror of the block: register file and wall flags.
  cfg_t     mirror;
  bit       wall_flags [SIDE*SIDE];
  landing_t landing_q [$];
  step_row_t dir_tab [$];

  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int errors = 0;
  int loads_sent = 0;
  int moves_sent = 0;
  int hits_seen = 0;
  int settings_run = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  aabb_tile_grid_slide_resolve #(.MAX_SIDE(SIDE)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------- predictor

  // Map registers above the grid side clamp to it; zero means no tiles.
  function automatic int eff_side(input logic [6:0] v);
    return (int'(v) > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Strict overlap of the box at (cx, cy, cz) with any wall tile in use.
  function automatic bit box_blocked(input int cx, input int cy, input int cz);
    int w, h, r, c, x0, x1, y0, y1, z0, z1;
    w  = eff_side(mirror.map_width);
    h  = eff_side(mirror.map_height);
    x0 = cx - int'(mirror.half_size_x);
    x1 = cx + int'(mirror.half_size_x);
    y0 = cy - int'(mirror.half_size_y);
    y1 = cy + int'(mirror.half_size_y);
    z0 = cz - int'(mirror.half_size_z);
    z1 = cz + int'(mirror.half_size_z);
    if (!(y0 < int'(mirror.wall_top) && y1 > 0)) return 1'b0;
    for (r = 0; r < h; r++) begin
      if (z0 < r * TILE_Q + TILE_Q && z1 > r * TILE_Q) begin
        for (c = 0; c < w; c++) begin
          if (wall_flags[r * w + c] && x0 < c * TILE_Q + TILE_Q && x1 > c * TILE_Q)
            return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // On a hit, restart from the old centre, keep y old, then slide x and z in turn.
  function automatic landing_t slide_resolve(input logic signed [15:0] ox, oy, oz,
                                             input logic signed [15:0] nx, ny, nz);
    landing_t l;
    l.x   = nx;
    l.y   = ny;
    l.z   = nz;
    l.hit = 1'b0;
    if (box_blocked(nx, ny, nz)) begin
      l.hit = 1'b1;
      l.y   = oy;
      if (box_blocked(nx, oy, oz)) l.x = ox;
      if (box_blocked(l.x, oy, nz)) l.z = oz;
    end
    return l;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one word after a random gap; update the mirror when it is taken.
  task automatic send_request(input logic kind, input logic [11:0] idx, input logic wall,
                              input logic signed [15:0] ox, oy, oz, nx, ny, nz,
                              input bit typed);
    int gap;
    landing_t want;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, nz, ny, nx, oz, oy, ox, wall, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == REQ_LOAD) begin
      wall_flags[idx] = wall;
      loads_sent++;
    end else begin
      if (typed) begin
        want.x   = nx;
        want.y   = ny;
        want.z   = nz;
        want.hit = 1'b0;
      end else begin
        want = slide_resolve(ox, oy, oz, nx, ny, nz);
      end
      landing_q.push_back(want);
      moves_sent++;
    end
  endtask

  // Hold until every move has landed, then let queued loads retire.
  task automatic await_idle();
    while (landing_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all six registers, optionally followed by writes to unused indexes.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] w, h, hx, hy, hz, wt,
                              input bit spare);
    logic [CFG_IDX_W-1:0]  idx_l [8];
    logic [CFG_DATA_W-1:0] val_l [8];
    int n, k;
    idx_l[0] = CFG_MAP_WIDTH;  val_l[0] = w;
    idx_l[1] = CFG_MAP_HEIGHT; val_l[1] = h;
    idx_l[2] = CFG_HALF_X;     val_l[2] = hx;
    idx_l[3] = CFG_HALF_Y;     val_l[3] = hy;
    idx_l[4] = CFG_HALF_Z;     val_l[4] = hz;
    idx_l[5] = CFG_WALL_TOP;   val_l[5] = wt;
    idx_l[6] = CFG_UNUSED_6;   val_l[6] = 15'h7FFF;
    idx_l[7] = CFG_UNUSED_7;   val_l[7] = 15'h0001;
    n = spare ? 8 : 6;
    for (k = 0; k < n; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_l[k];
      cfg_data_i <= val_l[k];
      case (idx_l[k])
        CFG_MAP_WIDTH:  mirror.map_width   = val_l[k][6:0];
        CFG_MAP_HEIGHT: mirror.map_height  = val_l[k][6:0];
        CFG_HALF_X:     mirror.half_size_x = val_l[k];
        CFG_HALF_Y:     mirror.half_size_y = val_l[k];
        CFG_HALF_Z:     mirror.half_size_z = val_l[k];
        CFG_WALL_TOP:   mirror.wall_top    = val_l[k];
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Proposed centre close to the old one, so that slides are common.
  function automatic logic signed [15:0] nudge(input logic signed [15:0] v);
    if ($urandom_range(0, 3) == 0) return v;
    return sat16(int'(v) + $urandom_range(0, 640) - 320);
  endfunction

  // One phase: reprogram while idle, then random loads and moves around the grid.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, h, hx, hy, hz, wt,
                           input int items, input bit spare, input bit hold,
                           input bit pause);
    int i, we, he, span_x, span_z, y_lo, y_hi;
    logic [11:0] idx;
    logic wall;
    logic signed [15:0] ox, oy, oz;
    await_idle();
    program_regs(w, h, hx, hy, hz, wt, spare);
    idle_on = ($urandom_range(0, 3) != 0);
    if (hold) long_hold_req = 1'b1;
    we     = eff_side(mirror.map_width);
    he     = eff_side(mirror.map_height);
    span_x = ((we > 0) ? we : 4) * TILE_Q + 768;
    span_z = ((he > 0) ? he : 4) * TILE_Q + 768;
    y_lo   = -int'(mirror.half_size_y) - TILE_Q;
    y_hi   = int'(mirror.wall_top) + int'(mirror.half_size_y) + TILE_Q;
    for (i = 0; i < items; i++) begin
      if (pause && i == items / 2) begin
        // Drop the word already taken before waiting for the results to drain.
        s_axis_tvalid <= 1'b0;
        while (landing_q.size() != 0) @(posedge clk);
      end
      idx  = $urandom;
      wall = $urandom;
      if ($urandom_range(0, 9) < 4) begin
        // Mostly flags inside the area in use; the rest anywhere in the store.
        if (we > 0 && he > 0 && $urandom_range(0, 4) != 0)
          idx = $urandom_range(0, he - 1) * we + $urandom_range(0, we - 1);
        wall = ($urandom_range(0, 99) < 35);
        send_request(REQ_LOAD, idx, wall, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 1'b0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_request(REQ_MOVE, idx, wall, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 1'b0);
      end else begin
        ox = sat16(int'($urandom_range(0, span_x)) - 384);
        oy = sat16(y_lo + int'($urandom_range(0, y_hi - y_lo)));
        oz = sat16(int'($urandom_range(0, span_z)) - 384);
        send_request(REQ_MOVE, idx, wall, ox, oy, oz, nudge(ox), nudge(oy), nudge(oz),
                     1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: random stalls, one long hold-off on request, then compare.
  initial begin : result_sink
    int stall;
    landing_t want;
    while (!rst_ni) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = idle_on ? $urandom_range(0, 4) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      if (landing_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = landing_q.pop_front();
        check_field("res_x", want.x, $signed(m_axis_tdata[15:0]));
        check_field("res_y", want.y, $signed(m_axis_tdata[31:16]));
        check_field("res_z", want.z, $signed(m_axis_tdata[47:32]));
        check_field("hit", want.hit, m_axis_tdata[48]);
        if (m_axis_tdata[48]) hits_seen++;
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, landing_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  function automatic step_row_t row(input logic kind, input logic [11:0] idx,
                                    input logic wall, input int ox, oy, oz, nx, ny, nz,
                                    input logic typed);
    step_row_t s;
    s.kind = kind; s.idx = idx; s.wall = wall; s.typed = typed;
    s.ox = ox[15:0]; s.oy = oy[15:0]; s.oz = oz[15:0];
    s.nx = nx[15:0]; s.ny = ny[15:0]; s.nz = nz[15:0];
    return s;
  endfunction

  initial begin : stimulus
    int k;
    int r;
    step_row_t s;
    mirror.map_width   = RST_MAP_WIDTH;
    mirror.map_height  = RST_MAP_HEIGHT;
    mirror.half_size_x = RST_HALF_X;
    mirror.half_size_y = RST_HALF_Y;
    mirror.half_size_z = RST_HALF_Z;
    mirror.wall_top    = RST_WALL_TOP;

    // Directed table at reset defaults: 64 x 64 grid, box 0.25/0.5/0.25 half size,
    // walls two tiles high. Typed rows run on an empty map.
    dir_tab.push_back(row(REQ_MOVE, 12'hABC, 1, 0, 0, 0, 100, 100, 100, 1));
    dir_tab.push_back(row(REQ_MOVE, 12'hFFF, 0, 32767, 32767, 32767,
                          -32768, -32768, -32768, 1));
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 1, -32768, -32768, -32768,
                          32767, 32767, 32767, 1));
    dir_tab.push_back(row(REQ_MOVE, 12'h555, 1, 0, 0, 0, 128, 128, 128, 1));
    // Walls at both corners and at column 1, row 1; move fields carry junk.
    dir_tab.push_back(row(REQ_LOAD, 12'd0, 1, -1, 32767, -32768, 21845, -21846, 1, 0));
    dir_tab.push_back(row(REQ_LOAD, 12'd4095, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(REQ_LOAD, 12'd65, 1, -1, -1, -1, -1, -1, -1, 0));
    // Straight into the corner wall, then touching its face, then just inside it.
    dir_tab.push_back(row(REQ_MOVE, 12'hFFF, 1, -512, 128, -512, 128, 128, 128, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 0, -512, 128, 128, -64, 128, 128, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 0, -512, 128, 128, -63, 128, 128, 0));
    // Above and below the wall span.
    dir_tab.push_back(row(REQ_MOVE, 12'h123, 1, 128, 128, -512, 128, 640, 128, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'h321, 0, 128, 128, -512, 128, -128, 128, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 0, 16000, 128, 15800, 16256, 128, 16256, 0));
    // Slide along x while z is blocked by the inner wall.
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 0, 384, 128, 128, 384, 128, 384, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 0, 300, 100, 120, 420, 300, 390, 0));
    dir_tab.push_back(row(REQ_LOAD, 12'd0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'h000, 0, -512, 128, -512, 128, 128, 128, 0));
    dir_tab.push_back(row(REQ_MOVE, 12'hFFF, 1, -32768, 32767, -32768,
                          32767, -32768, 32767, 0));
    dir_tab.push_back(row(REQ_LOAD, 12'd4095, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;

    for (k = 0; k < dir_tab.size(); k++) begin
      s = dir_tab[k];
      send_request(s.kind, s.idx, s.wall, s.ox, s.oy, s.oz, s.nx, s.ny, s.nz, s.typed);
    end
    s_axis_tvalid <= 1'b0;

    // Defaults rewritten, plus writes to the unused indexes that must change nothing.
    run_phase(64, 64, 64, 128, 64, 512, 150, 1'b1, 1'b0, 1'b0);
    // Small map with a long hold-off on the result side to back the block up.
    run_phase(8, 8, 200, 100, 300, 300, 160, 1'b0, 1'b1, 1'b0);
    // Oversized map registers clamp to the full grid; point-sized box, tallest walls.
    run_phase(127, 100, 0, 0, 0, 32767, 150, 1'b0, 1'b0, 1'b0);
    // Zero width, then zero height: nothing may collide.
    run_phase(0, 64, 64, 128, 64, 512, 100, 1'b0, 1'b0, 1'b0);
    run_phase(64, 0, 64, 128, 64, 512, 60, 1'b0, 1'b0, 1'b0);
    // Largest boxes: one tile, then the whole grid (slow, so few items).
    run_phase(1, 1, 32767, 32767, 32767, 0, 40, 1'b0, 1'b0, 1'b0);
    run_phase(64, 64, 32767, 32767, 32767, 32767, 30, 1'b0, 1'b0, 1'b0);
    // Map registers with stray upper data bits: only the low seven bits count.
    run_phase(15'h3F10, 15'h0104, 1, 1, 1, 1, 150, 1'b0, 1'b0, 1'b0);
    for (r = 0; r < 4; r++)
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 400),
                $urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 1024),
                150, 1'b0, 1'b0, (r == 0));

    await_idle();
    $display("Run covered %0d loads and %0d moves (%0d hits) over %0d register settings,",
             loads_sent, moves_sent, hits_seen, settings_run + 1);
    $display("including clamped and zero map sizes and the largest boxes.");
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
